FILE: src/chp_pkg.sv
// Shared types, phase codes and field sizes for the ClientHello field parser.
package chp_pkg;

    typedef enum logic [4:0] {
        PH_RECTYPE   = 5'd0,
        PH_RECVER    = 5'd1,
        PH_RECLEN    = 5'd2,
        PH_HSTYPE    = 5'd3,
        PH_HSLEN     = 5'd4,
        PH_CLIVER    = 5'd5,
        PH_RANDOM    = 5'd6,
        PH_SIDLEN    = 5'd7,
        PH_SID       = 5'd8,
        PH_CSLEN     = 5'd9,
        PH_CS        = 5'd10,
        PH_CMLEN     = 5'd11,
        PH_CM        = 5'd12,
        PH_EXTLEN    = 5'd13,
        PH_EXTTYPE   = 5'd14,
        PH_SNIEXTLEN = 5'd15,
        PH_LISTLEN   = 5'd16,
        PH_NAMETYPE  = 5'd17,
        PH_NAMELEN   = 5'd18,
        PH_HOSTNAME  = 5'd19,
        PH_IDLE      = 5'd20,
        PH_DONE      = 5'd21
    } phase_t;

    localparam logic [15:0] RANDOM_LEN = 16'd32;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_message;
    } in_item_t;

    typedef struct packed {
        logic [4:0]  field_kind;
        logic [23:0] field_value;
        logic [15:0] byte_index;
        logic        last_of_field;
    } out_item_t;

    // Size in bytes of a whole field; zero marks a byte-wise field.
    function automatic logic [1:0] field_size(input phase_t ph);
        logic [1:0] sz;
        begin
            case (ph)
                PH_RECTYPE, PH_HSTYPE, PH_SIDLEN, PH_CMLEN, PH_NAMETYPE:
                    sz = 2'd1;
                PH_HSLEN:
                    sz = 2'd3;
                PH_RANDOM, PH_SID, PH_CS, PH_CM, PH_HOSTNAME, PH_IDLE, PH_DONE:
                    sz = 2'd0;
                default:
                    sz = 2'd2;
            endcase
            return sz;
        end
    endfunction

endpackage

FILE: src/chp_parse.sv
// Parse state registers and the per-byte field decode.
module chp_parse (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  chp_pkg::in_item_t item,
    output logic              res_valid,
    output chp_pkg::out_item_t res
);

    chp_pkg::phase_t phase_reg, phase_next, phase_eff, adv_phase;
    logic [15:0] pos_reg, pos_next, pos_eff, pos_inc;
    logic [23:0] acc_reg, acc_next, acc_eff, acc_shift, adv_val;
    logic [15:0] left_reg, left_next, left_eff, adv_len;
    logic [1:0]  size;
    logic        bytewise;
    logic        last;
    logic        do_adv;

    always_comb
    begin
        // A start byte restarts the parse at the record type.
        if (item.start_of_message)
        begin
            phase_eff = chp_pkg::PH_RECTYPE;
            pos_eff   = '0;
            acc_eff   = '0;
            left_eff  = '0;
        end
        else
        begin
            phase_eff = phase_reg;
            pos_eff   = pos_reg;
            acc_eff   = acc_reg;
            left_eff  = left_reg;
        end
    end

    assign size      = chp_pkg::field_size(phase_eff);
    assign bytewise  = (size == 2'd0);
    assign last      = (left_eff <= 16'd1);
    assign pos_inc   = pos_eff + 16'd1;
    assign acc_shift = {acc_eff[15:0], item.data_byte};
    assign adv_val   = bytewise ? 24'd0 : acc_shift;

    // Next field after the current one completes.
    always_comb
    begin
        adv_len = '0;
        case (phase_eff)
            chp_pkg::PH_CLIVER:
            begin
                adv_phase = chp_pkg::PH_RANDOM;
                adv_len   = chp_pkg::RANDOM_LEN;
            end
            chp_pkg::PH_SIDLEN:
            begin
                adv_phase = (adv_val == '0) ? chp_pkg::PH_CSLEN : chp_pkg::PH_SID;
                adv_len   = adv_val[15:0];
            end
            chp_pkg::PH_CSLEN:
            begin
                adv_phase = (adv_val == '0) ? chp_pkg::PH_CMLEN : chp_pkg::PH_CS;
                adv_len   = adv_val[15:0];
            end
            chp_pkg::PH_CMLEN:
            begin
                adv_phase = (adv_val == '0) ? chp_pkg::PH_EXTLEN : chp_pkg::PH_CM;
                adv_len   = adv_val[15:0];
            end
            chp_pkg::PH_EXTLEN:
                adv_phase = (adv_val == '0) ? chp_pkg::PH_DONE : chp_pkg::PH_EXTTYPE;
            chp_pkg::PH_EXTTYPE:
                adv_phase = (adv_val == '0) ? chp_pkg::PH_SNIEXTLEN : chp_pkg::PH_DONE;
            chp_pkg::PH_NAMELEN:
            begin
                adv_phase = (adv_val == '0) ? chp_pkg::PH_DONE : chp_pkg::PH_HOSTNAME;
                adv_len   = adv_val[15:0];
            end
            chp_pkg::PH_HOSTNAME:
                adv_phase = chp_pkg::PH_DONE;
            default:
                adv_phase = chp_pkg::phase_t'(phase_eff + 5'd1);
        endcase
    end

    always_comb
    begin
        phase_next = phase_eff;
        pos_next   = pos_eff;
        acc_next   = acc_eff;
        left_next  = left_eff;
        res_valid  = 1'b0;
        do_adv     = 1'b0;
        res.field_kind    = phase_eff;
        res.field_value   = acc_shift;
        res.byte_index    = '0;
        res.last_of_field = 1'b1;
        if (phase_eff == chp_pkg::PH_IDLE || phase_eff == chp_pkg::PH_DONE)
        begin
            res_valid = 1'b0;
        end
        else if (bytewise)
        begin
            res_valid         = 1'b1;
            res.field_value   = {16'd0, item.data_byte};
            res.byte_index    = pos_eff;
            res.last_of_field = last;
            pos_next          = pos_inc;
            if (last)
                do_adv = 1'b1;
            else
                left_next = left_eff - 16'd1;
        end
        else
        begin
            acc_next = acc_shift;
            pos_next = pos_inc;
            if (pos_inc >= {14'd0, size})
            begin
                res_valid = 1'b1;
                do_adv    = 1'b1;
            end
        end
        if (do_adv)
        begin
            phase_next = adv_phase;
            pos_next   = '0;
            acc_next   = '0;
            left_next  = adv_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= chp_pkg::PH_IDLE;
            pos_reg   <= '0;
            acc_reg   <= '0;
            left_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
        end
    end

endmodule

FILE: src/tls_client_hello_field_parser_top.sv
// Top level of the ClientHello field parser: input register, parser, result register.
//
// Input channel in_valid/in_ready/in_data carries one record byte per transfer,
// with start_of_message set on the first byte of a record (it restarts parsing).
// Output channel out_valid/out_ready/out_data carries one field report per
// transfer: whole fields once on their last byte, byte-wise fields once per byte.
// Bytes that finish nothing (and bytes before a start or after the parse ends)
// give no output transfer.
// Path: a byte's report passes from the input register through the parser into
// the result register. Throughput: one byte per cycle unless out_ready stalls;
// the parse for a byte is combinational logic between the input and result registers.
// Reset: both registers empty, parser idle until a start byte arrives.
// Stall: while out_ready is low and a report is held, the input register holds
// its byte and in_ready drops once it is full; no report is lost or repeated.
module tls_client_hello_field_parser_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  chp_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output chp_pkg::out_item_t out_data
);

    logic               in_valid_reg;
    chp_pkg::in_item_t  in_data_reg;
    logic               out_valid_reg;
    chp_pkg::out_item_t out_data_reg;
    logic               out_free;
    logic               s1_go;
    logic               res_valid;
    chp_pkg::out_item_t res;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_go    = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_data_reg <= in_data;
    end

    chp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_go),
        .item      (in_data_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_go && res_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Load a new report only when the previous one is gone.
    always_ff @(posedge clk)
    begin
        if (s1_go && res_valid)
            out_data_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: tb/tls_client_hello_checker.sv
// Scoreboard for the ClientHello field parser: tracks the parse and checks every report.
module tls_client_hello_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  chp_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  chp_pkg::out_item_t out_data,
    output int                 mismatches,
    output int                 outstanding,
    output int                 bytes_taken,
    output int                 reports_taken
);
    timeunit 1ns;
    timeprecision 1ps;

    chp_pkg::phase_t phase;
    logic [15:0]     field_pos;
    logic [23:0]     field_acc;
    logic [15:0]     field_left;

    chp_pkg::out_item_t expected_fields[$];
    int                 err_n   = 0;
    int                 byte_n  = 0;
    int                 rep_n   = 0;

    // Bytes in a whole field; zero for fields reported one byte at a time.
    function automatic int whole_bytes(input chp_pkg::phase_t ph);
        int n;
        case (ph)
            chp_pkg::PH_RECTYPE, chp_pkg::PH_HSTYPE, chp_pkg::PH_SIDLEN,
            chp_pkg::PH_CMLEN, chp_pkg::PH_NAMETYPE:
                n = 1;
            chp_pkg::PH_HSLEN:
                n = 3;
            chp_pkg::PH_RECVER, chp_pkg::PH_RECLEN, chp_pkg::PH_CLIVER,
            chp_pkg::PH_CSLEN, chp_pkg::PH_EXTLEN, chp_pkg::PH_EXTTYPE,
            chp_pkg::PH_SNIEXTLEN, chp_pkg::PH_LISTLEN, chp_pkg::PH_NAMELEN:
                n = 2;
            default:
                n = 0;
        endcase
        return n;
    endfunction

    task automatic open_field(input chp_pkg::phase_t ph, input logic [15:0] len);
        phase      = ph;
        field_pos  = '0;
        field_acc  = '0;
        field_left = len;
    endtask

    // Pick the field that follows a completed one; empty lists are skipped.
    task automatic next_field(input chp_pkg::phase_t kind, input logic [23:0] v);
        case (kind)
            chp_pkg::PH_CLIVER:
                open_field(chp_pkg::PH_RANDOM, chp_pkg::RANDOM_LEN);
            chp_pkg::PH_SIDLEN:
                if (v == 0)
                    open_field(chp_pkg::PH_CSLEN, '0);
                else
                    open_field(chp_pkg::PH_SID, v[15:0]);
            chp_pkg::PH_CSLEN:
                if (v == 0)
                    open_field(chp_pkg::PH_CMLEN, '0);
                else
                    open_field(chp_pkg::PH_CS, v[15:0]);
            chp_pkg::PH_CMLEN:
                if (v == 0)
                    open_field(chp_pkg::PH_EXTLEN, '0);
                else
                    open_field(chp_pkg::PH_CM, v[15:0]);
            chp_pkg::PH_EXTLEN:
                if (v == 0)
                    open_field(chp_pkg::PH_DONE, '0);
                else
                    open_field(chp_pkg::PH_EXTTYPE, '0);
            chp_pkg::PH_EXTTYPE:
                if (v == 0)
                    open_field(chp_pkg::PH_SNIEXTLEN, '0);
                else
                    open_field(chp_pkg::PH_DONE, '0);
            chp_pkg::PH_NAMELEN:
                if (v == 0)
                    open_field(chp_pkg::PH_DONE, '0);
                else
                    open_field(chp_pkg::PH_HOSTNAME, v[15:0]);
            chp_pkg::PH_HOSTNAME:
                open_field(chp_pkg::PH_DONE, '0);
            default:
                open_field(chp_pkg::phase_t'(kind + 1), '0);
        endcase
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic som);
        chp_pkg::out_item_t e;
        chp_pkg::phase_t    kind;
        int                 need;
        logic               last;
        if (som)
            open_field(chp_pkg::PH_RECTYPE, '0);
        if (phase == chp_pkg::PH_IDLE || phase == chp_pkg::PH_DONE)
            return;
        kind = phase;
        need = whole_bytes(kind);
        if (need == 0)
        begin
            last            = (field_left <= 16'd1);
            e.field_kind    = kind;
            e.field_value   = {16'd0, b};
            e.byte_index    = field_pos;
            e.last_of_field = last;
            expected_fields.push_back(e);
            field_pos = field_pos + 16'd1;
            if (last)
                next_field(kind, '0);
            else
                field_left = field_left - 16'd1;
        end
        else
        begin
            field_acc = {field_acc[15:0], b};
            field_pos = field_pos + 16'd1;
            if (field_pos >= need)
            begin
                e.field_kind    = kind;
                e.field_value   = field_acc;
                e.byte_index    = '0;
                e.last_of_field = 1'b1;
                expected_fields.push_back(e);
                next_field(kind, field_acc);
            end
        end
    endtask

    task automatic check_report(input chp_pkg::out_item_t got);
        chp_pkg::out_item_t e;
        if (expected_fields.size() == 0)
        begin
            $error("report kind %0d value %0h index %0d with no field pending",
                   got.field_kind, got.field_value, got.byte_index);
            err_n++;
            return;
        end
        e = expected_fields.pop_front();
        if (got.field_kind !== e.field_kind)
        begin
            $error("field_kind: expected %0d, got %0d", e.field_kind, got.field_kind);
            err_n++;
        end
        if (got.field_value !== e.field_value)
        begin
            $error("field_value: expected %0h, got %0h", e.field_value, got.field_value);
            err_n++;
        end
        if (got.byte_index !== e.byte_index)
        begin
            $error("byte_index: expected %0d, got %0d", e.byte_index, got.byte_index);
            err_n++;
        end
        if (got.last_of_field !== e.last_of_field)
        begin
            $error("last_of_field: expected %0b, got %0b", e.last_of_field, got.last_of_field);
            err_n++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_field(chp_pkg::PH_IDLE, '0);
            expected_fields.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                parse_byte(in_data.data_byte, in_data.start_of_message);
                byte_n++;
            end
            if (out_valid && out_ready)
            begin
                check_report(out_data);
                rep_n++;
            end
        end
        mismatches    <= err_n;
        outstanding   <= expected_fields.size();
        bytes_taken   <= byte_n;
        reports_taken <= rep_n;
    end

endmodule

FILE: tb/tb.sv
// Testbench top: drives ClientHello records into the parser and gives the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EXT_NONE  = 0;
    localparam int EXT_SNI   = 1;
    localparam int EXT_OTHER = 2;

    logic               clk;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    chp_pkg::in_item_t  in_data   = '0;
    logic               out_ready = 1'b0;
    logic               in_ready;
    logic               out_valid;
    chp_pkg::out_item_t out_data;

    int        mismatches;
    int        outstanding;
    int        bytes_taken;
    int        reports_taken;

    logic [7:0] record_bytes[$];
    bit         steady     = 1'b0;
    int         sent       = 0;
    int         n_records  = 0;
    int         n_cut      = 0;
    int         n_noise    = 0;

    tls_client_hello_field_parser_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    tls_client_hello_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .bytes_taken   (bytes_taken),
        .reports_taken (reports_taken)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Report side: stall a random number of cycles before each transfer.
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    function automatic logic [7:0] pick(input int pad);
        if (pad < 0)
            return 8'($urandom_range(0, 255));
        return 8'(pad);
    endfunction

    task automatic put(input logic [23:0] v, input int n);
        int k;
        for (k = n - 1; k >= 0; k--)
            record_bytes.push_back(v[8*k +: 8]);
    endtask

    task automatic put_fill(input int n, input int pad);
        repeat (n) record_bytes.push_back(pick(pad));
    endtask

    // Hold the byte on the channel until the transfer; one assignment per edge.
    task automatic send_byte(input logic [7:0] b, input logic som);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, start_of_message: som};
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    task automatic drain(input int settle);
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (outstanding != 0 && waited < 5000);
        repeat (settle) @(posedge clk);
    endtask

    // Build one record; pad >= 0 fills every free byte with that value.
    task automatic send_record(input int sid_n, input int cs_n, input int cm_n,
                               input int ext_kind, input int name_n, input int cut,
                               input int tail, input int pad);
        int n;
        int i;
        record_bytes.delete();
        put_fill(1 + 2 + 2 + 1 + 3 + 2 + 32, pad);
        put(24'(sid_n), 1);
        put_fill(sid_n, pad);
        put(24'(cs_n), 2);
        put_fill(cs_n, pad);
        put(24'(cm_n), 1);
        put_fill(cm_n, pad);
        if (ext_kind == EXT_NONE)
            put(24'd0, 2);
        else
        begin
            put(pad > 0 ? {8'd0, pick(pad), pick(pad)} : 24'($urandom_range(1, 65535)), 2);
            if (ext_kind == EXT_OTHER)
                put(pad == 255 ? 24'hFFFF : 24'($urandom_range(1, 65535)), 2);
            else
            begin
                put(24'd0, 2);
                put_fill(2 + 2 + 1, pad);
                put(24'(name_n), 2);
                put_fill(name_n, pad);
            end
        end
        n = (cut > 0 && cut < record_bytes.size()) ? cut : record_bytes.size();
        if (n < record_bytes.size())
            n_cut++;
        for (i = 0; i < n; i++)
            send_byte(record_bytes[i], i == 0);
        repeat (tail) send_byte(pick(-1), 1'b0);
        n_records++;
    endtask

    task automatic send_noise();
        int n;
        int i;
        n = $urandom_range(8, 60);
        for (i = 0; i < n; i++)
            send_byte(pick(-1), i == 0);
        n_noise++;
    endtask

    task automatic send_random_record();
        int sid_n;
        int cs_n;
        int cm_n;
        int ext_kind;
        int name_n;
        int sel;
        sid_n  = ($urandom_range(0, 2) == 0) ? 0 :
                 (($urandom_range(0, 7) == 0) ? 32 : $urandom_range(1, 6));
        cs_n   = ($urandom_range(0, 2) == 0) ? 0 : 2 * $urandom_range(1, 4);
        cm_n   = $urandom_range(0, 2);
        sel    = $urandom_range(0, 9);
        ext_kind = (sel < 6) ? EXT_SNI : ((sel < 8) ? EXT_NONE : EXT_OTHER);
        name_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        // Cut some records short so the next start lands mid-record.
        send_record(sid_n, cs_n, cm_n, ext_kind, name_n,
                    ($urandom_range(0, 9) == 0) ? $urandom_range(1, 80) : 0,
                    $urandom_range(0, 3), -1);
    endtask

    initial
    begin
        bit mid_pause;
        mid_pause = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Bytes before any start are ignored.
        repeat (3) send_byte(pick(-1), 1'b0);
        send_record(0, 0, 0, EXT_NONE, 0, 0, 2, 0);
        send_record(1, 2, 1, EXT_SNI, 0, 0, 1, 255);
        send_record(0, 2, 0, EXT_OTHER, 0, 0, 2, 255);
        send_record(2, 0, 1, EXT_SNI, 3, 0, 0, -1);
        send_record(1, 2, 1, EXT_SNI, 4, 20, 0, -1);
        send_record(0, 0, 0, EXT_SNI, 1, 0, 1, -1);
        drain(6);

        sent = 0;
        while (sent < 600)
        begin
            steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                send_noise();
            else
                send_random_record();
            if (!mid_pause && sent >= 300)
            begin
                drain(6);
                mid_pause = 1'b1;
            end
        end
        steady = 1'b0;
        drain(8);

        $display("covered %0d bytes in %0d records (%0d cut short) and %0d noise bursts,",
                 bytes_taken, n_records, n_cut, n_noise);
        $display("checked %0d field reports across every field kind", reports_taken);
        if (outstanding != 0)
            $error("%0d expected field reports never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
